@@ design/unsd_pkg.sv @@
`default_nettype none

package unsd_pkg;

    // Frame and line limits
    localparam int unsigned MAX_FRAME   = 255;
    localparam int unsigned NMEA_CAP    = 128;

    // Output queue sizing
    localparam int unsigned MAX_RESULTS = 2;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Byte codes
    localparam logic [7:0] UBX_SYNC1  = 8'hB5;
    localparam logic [7:0] UBX_SYNC2  = 8'h62;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Route codes
    typedef enum logic [1:0] {
        ROUTE_UBX  = 2'd0,
        ROUTE_NMEA = 2'd1,
        ROUTE_DROP = 2'd2
    } t_route;

    // One result word
    typedef struct packed {
        t_route     route;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic       line_done;
        logic [7:0] line_length;
        logic       frame_done;
        logic       ack_seen;
        logic       power_save;
        logic       last;
    } t_result;

    // Result of appending one byte to the NMEA line
    typedef struct packed {
        t_result    res;
        logic [7:0] nmea_count;
        logic       has_dollar;
    } t_nmea_put;

    // Header of the CFG-RXM acknowledge: B5 62 05 01 02 00 06 11
    function automatic logic [7:0] ack_hdr(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'hB5;
            3'd1:    v = 8'h62;
            3'd2:    v = 8'h05;
            3'd3:    v = 8'h01;
            3'd4:    v = 8'h02;
            3'd5:    v = 8'h00;
            3'd6:    v = 8'h06;
            default: v = 8'h11;
        endcase
        return v;
    endfunction

    // Append a byte to the NMEA line, dropping it when the line is full
    function automatic t_nmea_put nmea_put(
        input logic [7:0] count,
        input logic       has_dollar,
        input logic [7:0] b,
        input logic       check_end
    );
        t_nmea_put p;
        p = '0;
        p.res.data_byte  = b;
        p.nmea_count     = count;
        p.has_dollar     = has_dollar;
        if (count >= 8'(NMEA_CAP)) begin
            p.res.route    = ROUTE_DROP;
            p.res.position = 8'(NMEA_CAP);
        end else begin
            p.res.route    = ROUTE_NMEA;
            p.res.position = count;
            if (count == 8'd0) begin
                p.has_dollar = (b == CH_DOLLAR);
            end
            p.nmea_count = count + 8'd1;
            if (check_end && p.has_dollar && (b == CH_NEWLINE)) begin
                p.res.line_done   = 1'b1;
                p.res.line_length = p.nmea_count;
                // terminator slot after a finished line
                if (p.nmea_count < 8'(NMEA_CAP)) begin
                    p.nmea_count = p.nmea_count + 8'd1;
                end
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ design/ubx_nmea_stream_demux.sv @@
`default_nettype none
// A result word is registered into the result queue when its input word is taken.
// Throughput: one input word per cycle while the queue has room; one result word
// per cycle at the output while the sink is ready. A UBX sync mismatch yields two
// result words; a four-entry result queue accepts input while up to two words wait.
// Reset: synchronous, active low; resets the parser state and empties the queue.

module ubx_nmea_stream_demux
    import unsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_axis_tuser,   // [0] batch_start
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [7:0] data_byte, [15:8] position,
                                               // [16] line_done, [24:17] line_length,
                                               // [25] frame_done, [26] ack_seen,
                                               // [27] power_save, [31:28] zero
    output logic [1:0]       o_m_axis_tuser,   // [1:0] route
    output logic             o_m_axis_tlast    // last
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // Parser state
    logic [7:0]  r_ubx_count, n_ubx_count;
    logic [16:0] r_ubx_total, n_ubx_total;
    logic [7:0]  r_ubx_len_low, n_ubx_len_low;
    logic        r_ack_match, n_ack_match;
    logic [7:0]  r_nmea_count, n_nmea_count;
    logic        r_has_dollar, n_has_dollar;
    logic        r_power_save, n_power_save;

    // Result queue
    t_result     r_queue [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic        in_fire, out_fire;
    logic        two_res;
    t_result     res0, res1;

    logic [7:0]  b;
    logic [7:0]  nc0, nc_line;
    logic [8:0]  cnt;
    logic        ack_now;
    t_nmea_put   p0, p1;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign b        = i_s_axis_tdata;

    // Byte classification and state update
    always_comb begin
        n_ubx_count   = r_ubx_count;
        n_ubx_total   = r_ubx_total;
        n_ubx_len_low = r_ubx_len_low;
        n_ack_match   = r_ack_match;
        n_has_dollar  = r_has_dollar;
        n_power_save  = r_power_save;
        two_res       = 1'b0;
        res0          = '0;
        res1          = '0;
        res0.data_byte = b;
        res0.route    = ROUTE_UBX;

        nc0          = i_s_axis_tuser ? 8'd0 : r_nmea_count;
        n_nmea_count = nc0;
        cnt          = {1'b0, r_ubx_count} + 9'd1;
        ack_now      = r_ack_match &&
                       !((r_ubx_count < 8'd8) && (b != ack_hdr(r_ubx_count[2:0])));
        nc_line      = ((b == CH_DOLLAR) || (nc0 >= 8'(NMEA_CAP - 1))) ? 8'd0 : nc0;

        p0 = nmea_put(nc0, r_has_dollar, UBX_SYNC1, 1'b0);
        p1 = nmea_put(p0.nmea_count, p0.has_dollar, b, 1'b0);

        if (r_ubx_count != 8'd0) begin
            // inside a UBX frame
            res0.position = r_ubx_count;
            n_ack_match   = ack_now;
            if (r_ubx_count == 8'd4) begin
                n_ubx_len_low = b;
            end
            if ((cnt == 9'd2) && (b != UBX_SYNC2)) begin
                // sync mismatch: replay both bytes into the line
                n_ubx_count  = 8'd0;
                n_ubx_total  = '0;
                two_res      = 1'b1;
                res0         = p0.res;
                res1         = p1.res;
                n_nmea_count = p1.nmea_count;
                n_has_dollar = p1.has_dollar;
            end else begin
                if (cnt == 9'd6) begin
                    n_ubx_total = 17'd8 + {1'b0, b, r_ubx_len_low};
                    n_ubx_count = cnt[7:0];
                end else if ((cnt > 9'd6) && ({8'd0, cnt} == r_ubx_total)) begin
                    res0.frame_done = 1'b1;
                    res0.ack_seen   = ack_now;
                    if (ack_now) begin
                        n_power_save = 1'b1;
                    end
                    n_ubx_count = 8'd0;
                    n_ubx_total = '0;
                end else begin
                    n_ubx_count = cnt[7:0];
                end
                // oversize frame is dropped
                if ((n_ubx_count != 8'd0) && (n_ubx_count >= 8'(MAX_FRAME))) begin
                    n_ubx_count = 8'd0;
                    n_ubx_total = '0;
                end
            end
        end else if (b == UBX_SYNC1) begin
            // frame start
            n_ubx_count = 8'd1;
            n_ubx_total = '0;
            n_ack_match = 1'b1;
        end else begin
            // ordinary NMEA byte
            p0           = nmea_put(nc_line, r_has_dollar, b, 1'b1);
            res0         = p0.res;
            n_nmea_count = p0.nmea_count;
            n_has_dollar = p0.has_dollar;
        end

        res0.power_save = n_power_save;
        res1.power_save = n_power_save;
        res0.last       = !two_res;
        res1.last       = 1'b1;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ubx_count   <= 8'd0;
            r_ubx_total   <= '0;
            r_ubx_len_low <= 8'd0;
            r_ack_match   <= 1'b1;
            r_nmea_count  <= 8'd0;
            r_has_dollar  <= 1'b0;
            r_power_save  <= 1'b0;
        end else if (in_fire) begin
            r_ubx_count   <= n_ubx_count;
            r_ubx_total   <= n_ubx_total;
            r_ubx_len_low <= n_ubx_len_low;
            r_ack_match   <= n_ack_match;
            r_nmea_count  <= n_nmea_count;
            r_has_dollar  <= n_has_dollar;
            r_power_save  <= n_power_save;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_queue[r_wr_ptr] <= res0;
            if (two_res) begin
                r_queue[r_wr_ptr + PW'(1)] <= res1;
            end
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_wr_ptr <= r_wr_ptr + (two_res ? PW'(2) : PW'(1));
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count
                     + (in_fire ? (two_res ? CW'(2) : CW'(1)) : CW'(0))
                     - (out_fire ? CW'(1) : CW'(0));
        end
    end

    // Ports
    assign o_s_axis_tready = (r_count <= CW'(QUEUE_DEPTH - MAX_RESULTS));
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tuser  = r_queue[r_rd_ptr].route;
    assign o_m_axis_tlast  = r_queue[r_rd_ptr].last;
    assign o_m_axis_tdata  = {4'd0,
                              r_queue[r_rd_ptr].power_save,
                              r_queue[r_rd_ptr].ack_seen,
                              r_queue[r_rd_ptr].frame_done,
                              r_queue[r_rd_ptr].line_length,
                              r_queue[r_rd_ptr].line_done,
                              r_queue[r_rd_ptr].position,
                              r_queue[r_rd_ptr].data_byte};

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ubx_count < 8'(MAX_FRAME))
        else $error("frame count reached the frame limit");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nmea_count <= 8'(NMEA_CAP))
        else $error("line position beyond the cap");

    a_ps_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power_save |=> r_power_save)
        else $error("power-save flag cleared");

endmodule

`default_nettype wire
